// ===== hdl/dq_pkg.sv =====
// dq_pkg: sizes and operation codes of the double-ended queue
// no dependencies; imported by double_ended_queue
`default_nettype none

package dq_pkg;

  // ring size and stored word width
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  // fixed port widths of the item fields
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // derived widths
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = IDX_W + 1;
  localparam int STORE_W = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT  = 3'd0,
    OP_ADD_BACK   = 3'd1,
    OP_REM_FRONT  = 3'd2,
    OP_REM_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  // status carried alongside the memory read
  typedef struct packed {
    logic             present;
    logic             refused;
    logic [CNT_W-1:0] count;
  } res_meta_t;

endpackage

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// double_ended_queue: bounded deque of words kept in a ring memory
// depends on dq_pkg for sizes, operation codes and the result status struct
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation and item_value; the
//   output channel (out_valid/out_ready) returns one item per input item with
//   result_value, was_present, add_refused and entry_count.
//   Front index and count live in registers; the words live in a synchronous
//   memory of DEPTH entries with a registered read. An item updates the
//   pointers and issues at most one read or write in the cycle it is
//   accepted; the read word is registered in rd_data and then moves to the
//   output register. Throughput is one item per cycle while the receiver
//   does not stall: pointer updates are done in the accept cycle, so the
//   next item sees them at once, and a read of an entry written by the
//   previous item finds the new word in the memory.
//   When the receiver stalls, the output register holds, the read stage holds
//   its word, and in_ready drops once both are full.
//   Reset (rst, synchronous) empties the queue and clears both stages; the
//   memory contents are not cleared and are never read before being written.
`default_nettype none

module double_ended_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dq_pkg::OP_W-1:0]     operation,
  input  wire logic [dq_pkg::VALUE_W-1:0]  item_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [dq_pkg::VALUE_W-1:0]       result_value,
  output logic                             was_present,
  output logic                             add_refused,
  output logic [dq_pkg::COUNT_W-1:0]       entry_count
);
  import dq_pkg::*;

  // ring position wrap for sums below twice the depth
  function automatic logic [IDX_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
    return r[IDX_W-1:0];
  endfunction

  // pointer state
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // word memory
  logic [STORE_W-1:0] entry_store [DEPTH];
  logic [STORE_W-1:0] rd_data;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   mem_addr;

  // read stage and output register
  logic               s1_valid;
  res_meta_t          s1_meta;
  res_meta_t          meta_next;
  logic [STORE_W-1:0] out_word;
  res_meta_t          out_meta;

  logic             accept;
  logic             advance;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] pos_prev;
  logic [IDX_W-1:0] pos_succ;
  logic [IDX_W-1:0] pos_tail;
  logic [IDX_W-1:0] pos_last;
  logic [SUM_W-1:0] tail_sum;

  // handshake
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  // ring positions around the front and back
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pos_prev = (front == '0) ? IDX_W'(DEPTH - 1) : (front - 1'b1);
  assign pos_succ = (front == IDX_W'(DEPTH - 1)) ? '0 : (front + 1'b1);
  assign tail_sum = SUM_W'(front) + SUM_W'(count);
  assign pos_tail = wrap_pos(tail_sum);
  assign pos_last = wrap_pos(tail_sum - 1'b1);

  // decode the operation into pointer updates and at most one memory access
  always_comb begin
    front_next        = front;
    count_next        = count;
    rd_en             = 1'b0;
    wr_en             = 1'b0;
    mem_addr          = front;
    meta_next.present = 1'b0;
    meta_next.refused = 1'b0;
    unique case (operation)
      OP_ADD_FRONT: begin
        if (full) begin
          meta_next.refused = 1'b1;
        end else begin
          front_next = pos_prev;
          count_next = count + 1'b1;
          mem_addr   = pos_prev;
          wr_en      = 1'b1;
        end
      end
      OP_ADD_BACK: begin
        if (full) begin
          meta_next.refused = 1'b1;
        end else begin
          count_next = count + 1'b1;
          mem_addr   = pos_tail;
          wr_en      = 1'b1;
        end
      end
      OP_REM_FRONT, OP_PEEK_FRONT: begin
        if (!empty) begin
          rd_en             = 1'b1;
          meta_next.present = 1'b1;
          if (operation == OP_REM_FRONT) begin
            front_next = pos_succ;
            count_next = count - 1'b1;
          end
        end
      end
      OP_REM_BACK, OP_PEEK_BACK: begin
        if (!empty) begin
          rd_en             = 1'b1;
          mem_addr          = pos_last;
          meta_next.present = 1'b1;
          if (operation == OP_REM_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    meta_next.count = count_next;
  end

  // pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  // ring memory, at most one access per accepted item
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      entry_store[mem_addr] <= item_value[STORE_W-1:0];
    end
    if (accept && rd_en) begin
      rd_data <= entry_store[mem_addr];
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_meta <= s1_meta;
      out_word <= s1_meta.present ? rd_data : '0;
    end
  end

  // result fields
  assign result_value = VALUE_W'(out_word);
  assign was_present  = out_meta.present;
  assign add_refused  = out_meta.refused;
  assign entry_count  = COUNT_W'(out_meta.count);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for the double_ended_queue block
// depends on dq_pkg for sizes and operation codes; holds a mirror of the
// ring and checks every returned item against it

import dq_pkg::*;

// unused operation codes, expected to change nothing
localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

typedef struct packed {
  logic [VALUE_W-1:0] value;
  logic               present;
  logic               refused;
  logic [COUNT_W-1:0] count;
} deque_result_t;

// mirror of the deque ring plus the list of results still owed by the block
class deque_mirror;
  logic [STORE_W-1:0] ring [DEPTH];
  int unsigned        head;
  int unsigned        held;
  deque_result_t      owed_results[$];
  int                 errors;

  function new();
    head   = 0;
    held   = 0;
    errors = 0;
  endfunction

  function int owed();
    return owed_results.size();
  endfunction

  // apply one accepted operation to the mirror and queue its result
  function void note_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] word);
    deque_result_t r;
    int unsigned   pos;
    bit            at_front;
    r = '0;
    case (op)
      OP_ADD_FRONT, OP_ADD_BACK: begin
        if (held >= DEPTH) begin
          r.refused = 1'b1;
        end else begin
          if (op == OP_ADD_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            pos  = head;
          end else begin
            pos = (head + held) % DEPTH;
          end
          ring[pos] = word[STORE_W-1:0];
          held++;
        end
      end
      OP_REM_FRONT, OP_REM_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (held != 0) begin
          at_front  = (op == OP_REM_FRONT) || (op == OP_PEEK_FRONT);
          pos       = at_front ? head : (head + held - 1) % DEPTH;
          r.value   = VALUE_W'(ring[pos]);
          r.present = 1'b1;
          if (op == OP_REM_FRONT) begin
            head = (head + 1) % DEPTH;
            held--;
          end else if (op == OP_REM_BACK) begin
            held--;
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(held);
    owed_results.push_back(r);
  endfunction

  // compare one returned item against the oldest owed result
  function void check_result(deque_result_t got);
    deque_result_t want;
    if (owed_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected item: value=%h present=%b refused=%b count=%0d",
                 got.value, got.present, got.refused, got.count);
      return;
    end
    want = owed_results.pop_front();
    if (got.value !== want.value || got.present !== want.present ||
        got.refused !== want.refused || got.count !== want.count) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: want value=%h present=%b refused=%b count=%0d, got value=%h present=%b refused=%b count=%0d",
                 want.value, want.present, want.refused, want.count,
                 got.value, got.present, got.refused, got.count);
    end
  endfunction
endclass

module tb;
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    operation = '0;
  logic [VALUE_W-1:0] item_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] result_value;
  logic               was_present;
  logic               add_refused;
  logic [COUNT_W-1:0] entry_count;

  deque_mirror mirror = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  double_ended_queue dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .was_present  (was_present),
    .add_refused  (add_refused),
    .entry_count  (entry_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // note accepted items before checking returned ones
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        mirror.note_op(operation, item_value);
      if (out_valid && out_ready)
        mirror.check_result('{result_value, was_present, add_refused, entry_count});
    end
  end

  // offer one item; entered and left just after a falling edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40)
      gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    operation  = op;
    item_value = word;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender pauses until every owed result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (mirror.owed() != 0)
      @(negedge clk);
  endtask

  // random operation; add_bias steers the fill level up or down
  function automatic logic [OP_W-1:0] pick_op(int add_bias);
    int r;
    r = $urandom_range(99);
    if (r < 3)
      return ($urandom_range(1) != 0) ? OP_SPARE_A : OP_SPARE_B;
    if (r < 3 + add_bias)
      return ($urandom_range(1) != 0) ? OP_ADD_FRONT : OP_ADD_BACK;
    case ($urandom_range(5))
      0:       return OP_PEEK_FRONT;
      1:       return OP_PEEK_BACK;
      2, 3:    return OP_REM_FRONT;
      default: return OP_REM_BACK;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // random items in stretches that fill toward full, then drain toward empty
  task automatic run_phase(int items, int idle_pct, int stall_pct);
    int bias;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      bias = ((n / 24) % 2 == 0) ? 72 : 25;
      send_item(pick_op(bias), pick_word());
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: empty queue, unused codes, fill past full, reads at both ends
    send_item(OP_PEEK_FRONT, 32'h1234_5678);
    send_item(OP_PEEK_BACK, '1);
    send_item(OP_REM_FRONT, '0);
    send_item(OP_REM_BACK, '1);
    send_item(OP_SPARE_A, '1);
    send_item(OP_SPARE_B, 32'hdead_beef);
    send_item(OP_ADD_FRONT, '0);
    send_item(OP_ADD_BACK, '1);
    for (int i = 0; i < DEPTH - 2; i++)
      send_item((i % 2 == 0) ? OP_ADD_FRONT : OP_ADD_BACK,
                (i % 2 == 0) ? 32'h5555_5555 ^ i : 32'haaaa_aaaa ^ i);
    send_item(OP_ADD_FRONT, 32'h0bad_0bad);
    send_item(OP_ADD_BACK, 32'hf00d_f00d);
    send_item(OP_PEEK_FRONT, '0);
    send_item(OP_PEEK_BACK, '0);
    send_item(OP_REM_FRONT, '0);
    send_item(OP_REM_BACK, '0);
    wait_drained();

    // random phases with different idling on each side
    run_phase(150, 0, 0);
    run_phase(150, 66, 0);
    run_phase(150, 0, 66);
    run_phase(150, 6, 6);

    // receiver holds off while the sender keeps offering, so input backs up
    hold_left = 60;
    run_phase(40, 0, 0);

    // let any late item surface before judging
    repeat (10) @(negedge clk);
    if (mirror.errors == 0 && mirror.owed() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
